// ===== src/dpb_pkg.sv =====
// Shared types and constants for the depth pixel back-projection core.
// No dependencies; imported by every other file of the block except dpb_checker.
package dpb_pkg;

   // Pipeline depth: stage 1 to stage 5 (stage 5 is the output register)
   localparam int NUM_STAGES = 5;

   // Image size and fixed valid window
   localparam logic [12:0] IMAGE_WIDTH  = 13'd640;
   localparam logic [12:0] IMAGE_HEIGHT = 13'd480;
   localparam logic [8:0]  WIN_ROW_LO   = 9'd30;
   localparam logic [8:0]  WIN_ROW_HI   = 9'd450;
   localparam logic [9:0]  WIN_COL_LO   = 10'd40;
   localparam logic [9:0]  WIN_COL_HI   = 10'd600;

   // Register indexes
   localparam logic [2:0] CSR_DEPTH_SCALE_RECIP = 3'd0;
   localparam logic [2:0] CSR_CENTER_X          = 3'd1;
   localparam logic [2:0] CSR_CENTER_Y          = 3'd2;
   localparam logic [2:0] CSR_FOCAL_X_RECIP     = 3'd3;
   localparam logic [2:0] CSR_FOCAL_Y_RECIP     = 3'd4;
   localparam logic [2:0] CSR_DEPTH_MIN         = 3'd5;
   localparam logic [2:0] CSR_DEPTH_MAX         = 3'd6;

   // Register reset values
   localparam logic [23:0] RST_DEPTH_SCALE_RECIP = 24'd16777;
   localparam logic [13:0] RST_CENTER_X          = 14'd5112;
   localparam logic [13:0] RST_CENTER_Y          = 14'd3832;
   localparam logic [23:0] RST_FOCAL_X_RECIP     = 24'd31957;
   localparam logic [23:0] RST_FOCAL_Y_RECIP     = 24'd31957;
   localparam logic [15:0] RST_DEPTH_MIN         = 16'd300;
   localparam logic [15:0] RST_DEPTH_MAX         = 16'd3600;

   // Saturation limits of the Q8.16 outputs
   localparam logic [23:0] POS_MAX = 24'h7FFFFF;
   localparam logic [23:0] NEG_MIN = 24'h800000;
   localparam logic [23:0] Z_MAX   = 24'hFFFFFF;

   typedef struct packed {
      logic [23:0] depth_scale_recip;
      logic [13:0] center_x;
      logic [13:0] center_y;
      logic [23:0] focal_x_recip;
      logic [23:0] focal_y_recip;
      logic [15:0] depth_min;
      logic [15:0] depth_max;
   } cfg_type;

   // Stage load enables and output valid from the pipeline control
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic                  out_valid;
   } pipe_ctrl_type;

   // Validity flag and colour travelling alongside the arithmetic
   typedef struct packed {
      logic       ok;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } side_type;

endpackage

// ===== src/dpb_csr.sv =====
// Configuration register file of the back-projection core.
// Depends on dpb_pkg (cfg_type, register indexes and reset values).
module dpb_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [23:0]      csr_wdata,
   output dpb_pkg::cfg_type cfg
);
   import dpb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEPTH_SCALE_RECIP: cfg_in.depth_scale_recip = csr_wdata;
            CSR_CENTER_X:          cfg_in.center_x          = csr_wdata[13:0];
            CSR_CENTER_Y:          cfg_in.center_y          = csr_wdata[13:0];
            CSR_FOCAL_X_RECIP:     cfg_in.focal_x_recip     = csr_wdata;
            CSR_FOCAL_Y_RECIP:     cfg_in.focal_y_recip     = csr_wdata;
            CSR_DEPTH_MIN:         cfg_in.depth_min         = csr_wdata[15:0];
            CSR_DEPTH_MAX:         cfg_in.depth_max         = csr_wdata[15:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_scale_recip <= RST_DEPTH_SCALE_RECIP;
         cfg_ff.center_x          <= RST_CENTER_X;
         cfg_ff.center_y          <= RST_CENTER_Y;
         cfg_ff.focal_x_recip     <= RST_FOCAL_X_RECIP;
         cfg_ff.focal_y_recip     <= RST_FOCAL_Y_RECIP;
         cfg_ff.depth_min         <= RST_DEPTH_MIN;
         cfg_ff.depth_max         <= RST_DEPTH_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/dpb_ctrl.sv =====
// Pipeline control: per-stage valid bits and the backward ready chain.
// Depends on dpb_pkg (NUM_STAGES, pipe_ctrl_type).
module dpb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   rsp_stall,
   output dpb_pkg::pipe_ctrl_type ctrl
);
   import dpb_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] ready;

   // A stage can load when it is empty or the stage after it moves on
   always_comb begin
      ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   always_comb begin
      valid_in[0] = ready[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall      = !ready[0];
   assign ctrl.load      = ready;
   assign ctrl.out_valid = valid_ff[NUM_STAGES-1];

endmodule

// ===== src/dpb_axis.sv =====
// One lateral axis of the back-projection: (pix*16 - centre) * recip * z,
// rounded half away from zero and saturated to Q8.16. Depends on dpb_pkg.
module dpb_axis (
   input  logic                   clock,
   input  dpb_pkg::pipe_ctrl_type ctrl,
   input  logic [9:0]             pix,
   input  logic [13:0]            centre,
   input  logic [23:0]            recip,
   input  logic [23:0]            z,        // rounded z, stage 3 output
   output logic [23:0]            pos_next  // feeds the stage 5 register
);
   import dpb_pkg::*;

   // stage 1: signed offset from the principal point, as sign and magnitude
   logic [13:0] p16;
   logic [13:0] dmag1_ff, dmag1_in;
   logic        neg1_ff, neg1_in;
   // stage 2 and 3: offset times reciprocal focal length
   logic [37:0] m2_ff, m2_in;
   logic        neg2_ff;
   logic [37:0] m3_ff;
   logic        neg3_ff;
   // stage 4: two partial products with z
   logic [42:0] pphi4_ff, pphi4_in;
   logic [42:0] pplo4_ff, pplo4_in;
   logic        neg4_ff;
   // stage 5 logic
   logic [62:0] sum;
   logic [34:0] mag;

   assign p16      = {pix, 4'b0000};
   assign neg1_in  = p16 < centre;
   assign dmag1_in = neg1_in ? (centre - p16) : (p16 - centre);

   assign m2_in    = {24'b0, dmag1_ff} * {14'b0, recip};

   assign pphi4_in = {24'b0, m3_ff[37:19]} * {19'b0, z};
   assign pplo4_in = {24'b0, m3_ff[18:0]}  * {19'b0, z};

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         dmag1_ff <= dmag1_in;
         neg1_ff  <= neg1_in;
      end
      if (ctrl.load[1]) begin
         m2_ff   <= m2_in;
         neg2_ff <= neg1_ff;
      end
      if (ctrl.load[2]) begin
         m3_ff   <= m2_ff;
         neg3_ff <= neg2_ff;
      end
      if (ctrl.load[3]) begin
         pphi4_ff <= pphi4_in;
         pplo4_ff <= pplo4_in;
         neg4_ff  <= neg3_ff;
      end
   end

   // Recombine, add half an LSB of Q8.16 and drop 28 fraction bits
   assign sum = {1'b0, pphi4_ff, 19'b0} + {20'b0, pplo4_ff} + 63'd134217728;
   assign mag = sum[62:28];

   always_comb begin
      if (neg4_ff) begin
         pos_next = (mag > {11'b0, NEG_MIN}) ? NEG_MIN : (24'd0 - mag[23:0]);
      end else begin
         pos_next = (mag > {11'b0, POS_MAX}) ? POS_MAX : mag[23:0];
      end
   end

endmodule

// ===== src/depth_pixel_backprojection_core.sv =====
// A pixel taken on req passes the five register stages in order; rsp_valid rises when
// it reaches stage 5, the output register. Throughput: one pixel per cycle while
// rsp_stall is low; each of the five register stages has its own valid bit.
// A held rsp_stall closes bubbles; req_stall rises only once all five stages are full.
// Reset (synchronous, active high) empties the pipeline and restores the
// register defaults; configuration writes are taken in every cycle.
module depth_pixel_backprojection_core (
   input  logic        clock,
   input  logic        reset,
   // pixel input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_depth,
   input  logic [8:0]  req_row,
   input  logic [9:0]  req_col,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_red,
   // point output channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_valid_res,
   output logic [23:0] rsp_pos_x,
   output logic [23:0] rsp_pos_y,
   output logic [23:0] rsp_pos_z,
   output logic [7:0]  rsp_out_blue,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_red,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import dpb_pkg::*;

   cfg_type       cfg;
   pipe_ctrl_type ctrl;

   // Stage 1: depth and window checks
   logic [15:0] depth1_ff;
   side_type    side1_ff, side1_in;
   // Stage 2: raw z product, Q16.24
   logic [39:0] zfull2_ff, zfull2_in;
   side_type    side2_ff;
   // Stage 3: z rounded to Q8.16 and saturated
   logic [40:0] zround;
   logic [23:0] z3_ff, z3_in;
   side_type    side3_ff;
   // Stage 4: z and side info wait beside the partial products
   logic [23:0] z4_ff;
   side_type    side4_ff;
   // Stage 5: output register, all fields zero for an invalid pixel
   logic [23:0] posx_next, posy_next;
   logic [23:0] posx5_ff, posx5_in;
   logic [23:0] posy5_ff, posy5_in;
   logic [23:0] z5_ff, z5_in;
   side_type    side5_ff, side5_in;

   dpb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dpb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   // Depth range is (min, max]; an inverted range rejects everything
   always_comb begin
      side1_in.ok = (req_depth > cfg.depth_min) && (req_depth <= cfg.depth_max)
                 && (req_row >= WIN_ROW_LO) && (req_row <= WIN_ROW_HI)
                 && (req_col >= WIN_COL_LO) && (req_col <= WIN_COL_HI)
                 && ({4'b0, req_row} < IMAGE_HEIGHT)
                 && ({3'b0, req_col} < IMAGE_WIDTH);
      side1_in.blue  = req_blue;
      side1_in.green = req_green;
      side1_in.red   = req_red;
   end

   assign zfull2_in = {24'b0, depth1_ff} * {16'b0, cfg.depth_scale_recip};

   // Round half up on the 8 dropped bits, clamp to 24 bits
   assign zround = {1'b0, zfull2_ff} + 41'd128;
   assign z3_in  = (|zround[40:32]) ? Z_MAX : zround[31:8];

   dpb_axis u_axis_x (
      .clock    (clock),
      .ctrl     (ctrl),
      .pix      (req_col),
      .centre   (cfg.center_x),
      .recip    (cfg.focal_x_recip),
      .z        (z3_ff),
      .pos_next (posx_next)
   );

   dpb_axis u_axis_y (
      .clock    (clock),
      .ctrl     (ctrl),
      .pix      ({1'b0, req_row}),
      .centre   (cfg.center_y),
      .recip    (cfg.focal_y_recip),
      .z        (z3_ff),
      .pos_next (posy_next)
   );

   always_comb begin
      posx5_in = side4_ff.ok ? posx_next : 24'd0;
      posy5_in = side4_ff.ok ? posy_next : 24'd0;
      z5_in    = side4_ff.ok ? z4_ff : 24'd0;
      side5_in = side4_ff.ok ? side4_ff : '0;
   end

   // Payload registers: no reset, they load whenever their stage moves
   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         depth1_ff <= req_depth;
         side1_ff  <= side1_in;
      end
      if (ctrl.load[1]) begin
         zfull2_ff <= zfull2_in;
         side2_ff  <= side1_ff;
      end
      if (ctrl.load[2]) begin
         z3_ff    <= z3_in;
         side3_ff <= side2_ff;
      end
      if (ctrl.load[3]) begin
         z4_ff    <= z3_ff;
         side4_ff <= side3_ff;
      end
      if (ctrl.load[4]) begin
         posx5_ff <= posx5_in;
         posy5_ff <= posy5_in;
         z5_ff    <= z5_in;
         side5_ff <= side5_in;
      end
   end

   assign rsp_valid     = ctrl.out_valid;
   assign rsp_valid_res = side5_ff.ok;
   assign rsp_pos_x     = posx5_ff;
   assign rsp_pos_y     = posy5_ff;
   assign rsp_pos_z     = z5_ff;
   assign rsp_out_blue  = side5_ff.blue;
   assign rsp_out_green = side5_ff.green;
   assign rsp_out_red   = side5_ff.red;

endmodule

// ===== src/dpb_checker.sv =====
// Port-level checks of the back-projection core, bound to the top level.
// Depends on depth_pixel_backprojection_core's port list only.
module dpb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_valid_res,
   input logic [23:0] rsp_pos_x,
   input logic [23:0] rsp_pos_y,
   input logic [23:0] rsp_pos_z,
   input logic [7:0]  rsp_out_blue,
   input logic [7:0]  rsp_out_green,
   input logic [7:0]  rsp_out_red
);

   // Rejected pixel carries nothing but the flag
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_pos_x == 24'd0 && rsp_pos_y == 24'd0
         && rsp_pos_z == 24'd0 && rsp_out_blue == 8'd0 && rsp_out_green == 8'd0
         && rsp_out_red == 8'd0)
      else $error("invalid point with non-zero payload");

   // A zero z must give a point at the origin
   a_zero_z_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pos_z == 24'd0 |-> rsp_pos_x == 24'd0 && rsp_pos_y == 24'd0)
      else $error("z is zero but x or y is not");

   // Empty output slot means the whole pipe can move
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while the output is empty");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_valid_res)
         && $stable(rsp_pos_x) && $stable(rsp_pos_y) && $stable(rsp_pos_z)
         && $stable(rsp_out_blue) && $stable(rsp_out_green) && $stable(rsp_out_red))
      else $error("stalled result changed");

endmodule

bind depth_pixel_backprojection_core dpb_checker u_dpb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_valid_res (rsp_valid_res),
   .rsp_pos_x     (rsp_pos_x),
   .rsp_pos_y     (rsp_pos_y),
   .rsp_pos_z     (rsp_pos_z),
   .rsp_out_blue  (rsp_out_blue),
   .rsp_out_green (rsp_out_green),
   .rsp_out_red   (rsp_out_red)
);

// ===== verif/tb.sv =====
// Self-checking bench for depth_pixel_backprojection_core: directed pixels, then random phases
// under several register settings and handshake patterns, checked by a local model or by hand.
// Depends on dpb_pkg (register indexes, reset values, window limits) and the core itself.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dpb_pkg::*;

   // Index past the end of the register file: a write there must change nothing
   localparam logic [2:0] CSR_SPARE = 3'd7;

   localparam int NUM_DIRECTED    = 20;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 230;
   localparam int LONG_HOLD       = 300;     // cycles the receiver refuses points
   localparam int CYCLE_LIMIT     = 400000;  // far beyond the slowest correct run

   // One RGB-D pixel, in port order so it can be driven onto the req_ ports in one go
   typedef struct packed {
      logic [15:0] depth;
      logic [8:0]  row;
      logic [9:0]  col;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
   } pixel_type;

   // One back-projected point
   typedef struct packed {
      logic        valid_res;
      logic [23:0] pos_x;
      logic [23:0] pos_y;
      logic [23:0] pos_z;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
   } point_type;

   // Directed stimulus row: when hand_set is high the point below is the answer,
   // otherwise the answer comes from the local model.
   typedef struct packed {
      pixel_type px;
      logic      hand_set;
      point_type pt;
   } dir_row_type;

   localparam point_type NO_POINT = '0;

   // Directed pixels, all under the reset register values (depth range 300 < d <= 3600).
   // Rejected pixels must come out as all zeros, colour included.
   localparam dir_row_type DIRECTED [NUM_DIRECTED] = '{
      '{'{16'd0,    9'd240, 10'd320, 8'hFF, 8'hFF, 8'hFF}, 1'b1, NO_POINT}, // no depth
      '{'{16'd300,  9'd240, 10'd320, 8'hFF, 8'h80, 8'h01}, 1'b1, NO_POINT}, // at depth_min
      '{'{16'd301,  9'd240, 10'd320, 8'h12, 8'h34, 8'h56}, 1'b0, NO_POINT}, // just above
      '{'{16'd3600, 9'd240, 10'd320, 8'hFF, 8'h00, 8'hFF}, 1'b0, NO_POINT}, // at depth_max
      '{'{16'd3601, 9'd240, 10'd320, 8'hFF, 8'hFF, 8'hFF}, 1'b1, NO_POINT}, // just beyond
      '{'{16'hFFFF, 9'd240, 10'd320, 8'hFF, 8'hFF, 8'hFF}, 1'b1, NO_POINT}, // full scale
      '{'{16'd1500, 9'd29,  10'd320, 8'hA5, 8'h5A, 8'hA5}, 1'b1, NO_POINT}, // above window
      '{'{16'd1500, 9'd30,  10'd320, 8'h01, 8'h02, 8'h03}, 1'b0, NO_POINT},
      '{'{16'd1500, 9'd450, 10'd320, 8'h04, 8'h05, 8'h06}, 1'b0, NO_POINT},
      '{'{16'd1500, 9'd451, 10'd320, 8'hA5, 8'h5A, 8'hA5}, 1'b1, NO_POINT}, // below window
      '{'{16'd1500, 9'd240, 10'd39,  8'hA5, 8'h5A, 8'hA5}, 1'b1, NO_POINT}, // left of it
      '{'{16'd1500, 9'd240, 10'd40,  8'h07, 8'h08, 8'h09}, 1'b0, NO_POINT},
      '{'{16'd1500, 9'd240, 10'd600, 8'h0A, 8'h0B, 8'h0C}, 1'b0, NO_POINT},
      '{'{16'd1500, 9'd240, 10'd601, 8'hA5, 8'h5A, 8'hA5}, 1'b1, NO_POINT}, // right of it
      '{'{16'd2000, 9'd479, 10'd639, 8'hFF, 8'hFF, 8'hFF}, 1'b1, NO_POINT}, // last pixel
      '{'{16'd0,    9'd0,   10'd0,   8'h00, 8'h00, 8'h00}, 1'b1, NO_POINT}, // first pixel
      '{'{16'd3600, 9'd30,  10'd40,  8'h00, 8'h00, 8'h00}, 1'b0, NO_POINT}, // far corner
      '{'{16'd3600, 9'd450, 10'd600, 8'hFF, 8'hFF, 8'hFF}, 1'b0, NO_POINT}, // opposite one
      '{'{16'd1000, 9'd255, 10'd511, 8'hAA, 8'h55, 8'hAA}, 1'b0, NO_POINT},
      '{'{16'd2048, 9'd256, 10'd512, 8'h55, 8'hAA, 8'h55}, 1'b0, NO_POINT}
   };

   // Block inputs, all known from time zero
   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic [15:0] req_depth = '0;
   logic [8:0]  req_row   = '0;
   logic [9:0]  req_col   = '0;
   logic [7:0]  req_blue  = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_red   = '0;
   logic        rsp_stall = 1'b0;
   logic        csr_valid = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   // Block outputs
   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_valid_res;
   logic [23:0] rsp_pos_x;
   logic [23:0] rsp_pos_y;
   logic [23:0] rsp_pos_z;
   logic [7:0]  rsp_out_blue;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_red;
   logic        csr_ready;

   // Bench state
   cfg_type   csr_shadow;           // what the register file should hold
   point_type pending_points [$];   // points owed by the core, oldest first
   int        fault_count    = 0;
   int        cycle_count    = 0;
   int        send_idle_pct  = 0;   // chance of a gap before each pixel
   int        take_stall_pct = 0;   // chance of rsp_stall in each cycle
   bit        hold_req       = 1'b0;
   int        hold_left      = 0;

   depth_pixel_backprojection_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_depth     (req_depth),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_blue      (req_blue),
      .req_green     (req_green),
      .req_red       (req_red),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_valid_res (rsp_valid_res),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_pos_z     (rsp_pos_z),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_green (rsp_out_green),
      .rsp_out_red   (rsp_out_red),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Local model
   // ------------------------------------------------------------------

   // Offset of one axis in metres: (pixel*16 - centre) * z * recip carries 44 fraction
   // bits; the magnitude is rounded half away from zero down to Q8.16, the sign put back
   // and the result clipped to the signed 24-bit range.
   function automatic logic [23:0] axis_offset(logic [9:0] pix, logic [13:0] centre,
                                               logic [23:0] z, logic [23:0] recip);
      logic [13:0] pix_q4;
      logic        neg;
      logic [13:0] dmag;
      logic [63:0] prod;
      logic [63:0] mag;
      pix_q4 = {pix, 4'b0};
      neg    = pix_q4 < centre;
      dmag   = neg ? centre - pix_q4 : pix_q4 - centre;
      prod   = 64'(dmag) * 64'(z) * 64'(recip);
      mag    = (prod + (64'd1 << 27)) >> 28;
      if (neg) begin
         if (mag > 64'd8388608)
            mag = 64'd8388608;
         return 24'(64'd0 - mag);
      end
      if (mag > 64'(POS_MAX))
         mag = 64'(POS_MAX);
      return mag[23:0];
   endfunction

   // Point that a pixel must turn into under the current register values
   function automatic point_type backproject(pixel_type px);
      logic        ok;
      logic [39:0] z_full;
      logic [39:0] z_round;
      logic [23:0] z;
      point_type   pt;
      pt = '0;
      ok = px.depth > csr_shadow.depth_min && px.depth <= csr_shadow.depth_max
         && px.row >= WIN_ROW_LO && px.row <= WIN_ROW_HI
         && px.col >= WIN_COL_LO && px.col <= WIN_COL_HI
         && 13'(px.row) < IMAGE_HEIGHT && 13'(px.col) < IMAGE_WIDTH;
      if (!ok)
         return pt;
      // depth (Q16) times Q0.24 is Q16.24; round half up into Q8.16, clip at the top
      z_full  = 40'(px.depth) * 40'(csr_shadow.depth_scale_recip);
      z_round = (z_full + 40'd128) >> 8;
      z       = (z_round > 40'(Z_MAX)) ? Z_MAX : z_round[23:0];
      pt.valid_res = 1'b1;
      pt.pos_x = axis_offset(px.col, csr_shadow.center_x, z, csr_shadow.focal_x_recip);
      pt.pos_y = axis_offset({1'b0, px.row}, csr_shadow.center_y, z,
                             csr_shadow.focal_y_recip);
      pt.pos_z = z;
      pt.blue  = px.blue;
      pt.green = px.green;
      pt.red   = px.red;
      return pt;
   endfunction

   // Append a point to the tail of the owed list
   task automatic owe_point(point_type pt);
      pending_points.insert(pending_points.size(), pt);
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers (all entered and left at a falling edge)
   // ------------------------------------------------------------------

   // Offer one pixel; random gaps come first and carry junk payload. Once offered the
   // payload holds until the transfer, and valid stays high for a following pixel.
   task automatic send_pixel(pixel_type px, logic hand_set, point_type hand_pt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         {req_depth, req_row, req_col, req_blue, req_green, req_red}
            <= 59'({$urandom, $urandom});
         @(negedge clock);
      end
      req_valid <= 1'b1;
      {req_depth, req_row, req_col, req_blue, req_green, req_red} <= px;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      owe_point(hand_set ? hand_pt : backproject(px));
      @(negedge clock);
   endtask

   // Drop valid and wait until every owed point has come out
   task automatic drain_points();
      req_valid <= 1'b0;
      while (pending_points.size() != 0)
         @(posedge clock);
      repeat (NUM_STAGES) @(posedge clock);
      @(negedge clock);
   endtask

   // One register write; csr_valid is left high for a following write
   task automatic write_csr(logic [2:0] idx, logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_DEPTH_SCALE_RECIP: csr_shadow.depth_scale_recip = val;
         CSR_CENTER_X:          csr_shadow.center_x          = val[13:0];
         CSR_CENTER_Y:          csr_shadow.center_y          = val[13:0];
         CSR_FOCAL_X_RECIP:     csr_shadow.focal_x_recip     = val;
         CSR_FOCAL_Y_RECIP:     csr_shadow.focal_y_recip     = val;
         CSR_DEPTH_MIN:         csr_shadow.depth_min         = val[15:0];
         CSR_DEPTH_MAX:         csr_shadow.depth_max         = val[15:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Register settings per phase; the core is idle whenever this runs
   task automatic set_registers(int phase);
      int v;
      case (phase)
         2: begin
            // everything at full scale: z, x and y saturate
            write_csr(CSR_DEPTH_SCALE_RECIP, 24'hFFFFFF);
            write_csr(CSR_CENTER_X,          24'hFFFFFF);
            write_csr(CSR_CENTER_Y,          24'hFFFFFF);
            write_csr(CSR_FOCAL_X_RECIP,     24'hFFFFFF);
            write_csr(CSR_FOCAL_Y_RECIP,     24'hFFFFFF);
            write_csr(CSR_DEPTH_MIN,         24'h000000);
            write_csr(CSR_DEPTH_MAX,         24'hFFFFFF);
         end
         3: begin
            // zero reciprocals and centres: valid points with zero coordinates
            write_csr(CSR_DEPTH_SCALE_RECIP, 24'h000000);
            write_csr(CSR_CENTER_X,          24'h000000);
            write_csr(CSR_CENTER_Y,          24'h000000);
            write_csr(CSR_FOCAL_X_RECIP,     24'h000000);
            write_csr(CSR_FOCAL_Y_RECIP,     24'h000000);
            write_csr(CSR_DEPTH_MIN,         24'h000000);
            write_csr(CSR_DEPTH_MAX,         24'h00FFFF);
         end
         5: begin
            // empty depth range (min equal to max) rejects everything; the spare
            // index takes a write that must be dropped
            v = $urandom_range(65535);
            write_csr(CSR_DEPTH_MIN, 24'(v));
            write_csr(CSR_DEPTH_MAX, 24'(v));
            write_csr(CSR_SPARE,     24'($urandom));
         end
         6: begin
            // raw random words on every register, upper bits included
            for (int i = CSR_DEPTH_SCALE_RECIP; i <= CSR_DEPTH_MAX; i++)
               write_csr(3'(i), 24'($urandom));
            write_csr(CSR_SPARE, 24'($urandom));
         end
         8: begin
            write_csr(CSR_DEPTH_SCALE_RECIP, 24'(RST_DEPTH_SCALE_RECIP));
            write_csr(CSR_CENTER_X,          24'(RST_CENTER_X));
            write_csr(CSR_CENTER_Y,          24'(RST_CENTER_Y));
            write_csr(CSR_FOCAL_X_RECIP,     24'(RST_FOCAL_X_RECIP));
            write_csr(CSR_FOCAL_Y_RECIP,     24'(RST_FOCAL_Y_RECIP));
            write_csr(CSR_DEPTH_MIN,         24'(RST_DEPTH_MIN));
            write_csr(CSR_DEPTH_MAX,         24'(RST_DEPTH_MAX));
         end
         default: begin
            // a plausible camera with randomised intrinsics and depth range
            write_csr(CSR_DEPTH_SCALE_RECIP, 24'($urandom_range(40000, 4000)));
            write_csr(CSR_CENTER_X,          24'($urandom_range(6400, 3800)));
            write_csr(CSR_CENTER_Y,          24'($urandom_range(4800, 2800)));
            write_csr(CSR_FOCAL_X_RECIP,     24'($urandom_range(60000, 15000)));
            write_csr(CSR_FOCAL_Y_RECIP,     24'($urandom_range(60000, 15000)));
            write_csr(CSR_DEPTH_MIN,         24'($urandom_range(800, 0)));
            write_csr(CSR_DEPTH_MAX,         24'($urandom_range(20000, 2000)));
         end
      endcase
      csr_valid <= 1'b0;
   endtask

   // Random pixel: mostly inside window and depth range, some on the edges of
   // both, the rest anywhere in the image
   function automatic pixel_type random_pixel();
      int        lo;
      int        hi;
      int        pick;
      pixel_type px;
      lo   = csr_shadow.depth_min;
      hi   = csr_shadow.depth_max;
      pick = $urandom_range(99);
      px.blue  = 8'($urandom);
      px.green = 8'($urandom);
      px.red   = 8'($urandom);
      if (pick < 70 && lo < hi) begin
         px.depth = 16'($urandom_range(hi, lo + 1));
         px.row   = 9'($urandom_range(WIN_ROW_HI, WIN_ROW_LO));
         px.col   = 10'($urandom_range(WIN_COL_HI, WIN_COL_LO));
      end else if (pick < 85) begin
         case ($urandom_range(3))
            0: px.depth = 16'(lo);
            1: px.depth = 16'(lo + 1);
            2: px.depth = 16'(hi);
            default: px.depth = 16'(hi + 1);
         endcase
         case ($urandom_range(3))
            0: px.row = WIN_ROW_LO - 9'd1;
            1: px.row = WIN_ROW_LO;
            2: px.row = WIN_ROW_HI;
            default: px.row = WIN_ROW_HI + 9'd1;
         endcase
         case ($urandom_range(3))
            0: px.col = WIN_COL_LO - 10'd1;
            1: px.col = WIN_COL_LO;
            2: px.col = WIN_COL_HI;
            default: px.col = WIN_COL_HI + 10'd1;
         endcase
      end else begin
         px.depth = 16'($urandom);
         px.row   = 9'($urandom_range(IMAGE_HEIGHT - 1));
         px.col   = 10'($urandom_range(IMAGE_WIDTH - 1));
      end
      return px;
   endfunction

   // ------------------------------------------------------------------
   // Receiver: random stall, or a long hold-off counted here on request
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = LONG_HOLD;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < take_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Checker: every point transfer against the oldest owed point
   // ------------------------------------------------------------------
   task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            $error("point transfer with no pixel outstanding");
            fault_count++;
         end else begin
            want = pending_points.pop_front();
            check_field("valid_res", 24'(want.valid_res), 24'(rsp_valid_res));
            check_field("pos_x",     want.pos_x,          rsp_pos_x);
            check_field("pos_y",     want.pos_y,          rsp_pos_y);
            check_field("pos_z",     want.pos_z,          rsp_pos_z);
            check_field("out_blue",  24'(want.blue),      24'(rsp_out_blue));
            check_field("out_green", 24'(want.green),     24'(rsp_out_green));
            check_field("out_red",   24'(want.red),       24'(rsp_out_red));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      csr_shadow = '{RST_DEPTH_SCALE_RECIP, RST_CENTER_X, RST_CENTER_Y, RST_FOCAL_X_RECIP,
                     RST_FOCAL_Y_RECIP, RST_DEPTH_MIN, RST_DEPTH_MAX};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed pixels at reset values, no gaps and no stalls
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_pixel(DIRECTED[i].px, DIRECTED[i].hand_set, DIRECTED[i].pt);
      drain_points();

      // Random phases: new register setting, then a handshake pattern that cycles
      // through none / sender gaps / receiver stalls / both lightly
      for (int phase = 1; phase <= NUM_PHASES; phase++) begin
         set_registers(phase);
         case (phase % 4)
            0: begin send_idle_pct = 0;  take_stall_pct = 0;  end
            1: begin send_idle_pct = 52; take_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  take_stall_pct = 52; end
            default: begin send_idle_pct = 14; take_stall_pct = 14; end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // long receiver hold-off while pixels keep coming: the pipe fills and
            // req_stall rises
            if (phase == 4 && n == 40)
               hold_req = 1'b1;
            // sender stops until every owed point is out, then carries on
            if (phase == 7 && n == 120)
               drain_points();
            send_pixel(random_pixel(), 1'b0, NO_POINT);
         end
         drain_points();
      end

      repeat (2 * NUM_STAGES) @(posedge clock);
      if (fault_count == 0 && pending_points.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== depth_pixel_backprojection_core.f =====
src/dpb_pkg.sv
src/dpb_csr.sv
src/dpb_ctrl.sv
src/dpb_axis.sv
src/depth_pixel_backprojection_core.sv
src/dpb_checker.sv
verif/tb.sv
